// ===== src/xtea_pkg.sv =====
// Shared types and constants for the XTEA block cipher pipeline.
// Holds the item structs, the key array type and the per-stage round sums.
// No dependencies.
package xtea_pkg;

    localparam int ROUNDS = 32;
    localparam int NSTAGE = 2 * ROUNDS;
    localparam int KEY_WORDS = 4;
    localparam int CFG_INDEX_W = 3;
    localparam logic [31:0] DELTA = 32'h9E3779B9;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef struct packed {
        logic        op;
        logic [31:0] left_word;
        logic [31:0] right_word;
    } in_item_t;

    typedef struct packed {
        logic [31:0] out_left;
        logic [31:0] out_right;
    } out_item_t;

    typedef struct packed {
        logic        valid;
        logic        op;
        logic [31:0] left;
        logic [31:0] right;
    } pipe_t;

    typedef logic [KEY_WORDS-1:0][31:0] key_t;

    // Round sum used by half-round h; decryption walks the sums backward.
    function automatic logic [31:0] stage_sum(input int h, input logic dec);
        int          r;
        int          cnt;
        logic [31:0] mult;
        r = h >> 1;
        if (dec)
        begin
            cnt = ROUNDS - r - (h & 1);
        end
        else
        begin
            cnt = r + (h & 1);
        end
        mult = 32'(cnt);
        return mult * DELTA;
    endfunction

endpackage

// ===== src/xtea_block_cipher.sv =====
// Top level of the XTEA block cipher: key registers and a chain of half-round stages.
// Uses xtea_pkg, xtea_key_regs and xtea_half_round.
//
// Usage:
//   An item (direction bit and two 32-bit words) is accepted on a rising edge
//   where start is high and busy is low. busy stays low, so one item can be
//   accepted every cycle.
//   The key is written through the cfg_valid/cfg_ready channel, cfg_index 0 to 3
//   selecting the key word; other indexes are ignored. cfg_ready is always high.
//   Keys should only change while no item is in flight.
//   Each item passes through one register stage per half-round, 2 * ROUNDS
//   stages in all, and its result leaves the last stage with
//   result_valid high for exactly one cycle. Throughput is one item per cycle,
//   set by the fully unrolled half-round chain.
//   The receiver cannot stall; results leave in the order items were accepted.
//   Reset clears the key words to zero and drops every item in flight.
module xtea_block_cipher
    import xtea_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  in_item_t               block,
    output logic                   result_valid,
    output out_item_t              result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    key_t  keys;
    pipe_t pipe [NSTAGE+1];

    xtea_key_regs u_keys (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .keys      (keys)
    );

    assign busy = 1'b0;

    assign pipe[0].valid = start && !busy;
    assign pipe[0].op    = block.op;
    assign pipe[0].left  = block.left_word;
    assign pipe[0].right = block.right_word;

    for (genvar h = 0; h < NSTAGE; h++)
    begin : g_stage
        xtea_half_round u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (pipe[h]),
            .keys      (keys),
            .enc_sum   (stage_sum(h, 1'b0)),
            .dec_sum   (stage_sum(h, 1'b1)),
            .odd_stage ((h % 2) == 1),
            .stage_out (pipe[h+1])
        );
    end

    assign result_valid     = pipe[NSTAGE].valid;
    assign result.out_left  = pipe[NSTAGE].left;
    assign result.out_right = pipe[NSTAGE].right;

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##NSTAGE result_valid)
        else $error("accepted item did not produce a result after the pipeline latency");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, NSTAGE))
        else $error("result strobe without a matching accepted item");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(block.op, NSTAGE) == pipe[NSTAGE].op)
        else $error("direction bit lost along the pipeline");

endmodule

// ===== src/xtea_key_regs.sv =====
// Key register file for the XTEA block cipher.
// Takes indexed writes from the configuration channel; uses xtea_pkg.
module xtea_key_regs
    import xtea_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data,
    output key_t                   keys
);

    key_t key_reg;
    key_t key_next;

    always_comb
    begin
        key_next = key_reg;
        if (cfg_valid && (cfg_index < CFG_INDEX_W'(KEY_WORDS)))
        begin
            key_next[cfg_index[1:0]] = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign keys      = key_reg;

endmodule

// ===== src/xtea_half_round.sv =====
// One registered XTEA half-round stage, usable for both directions.
// The round sums for each direction arrive as constants; uses xtea_pkg.
module xtea_half_round
    import xtea_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pipe_t       stage_in,
    input  key_t        keys,
    input  logic [31:0] enc_sum,
    input  logic [31:0] dec_sum,
    input  logic        odd_stage,
    output pipe_t       stage_out
);

    logic        upd_left;
    logic [31:0] sum;
    logic [31:0] src;
    logic [31:0] dst;
    logic [1:0]  kidx;
    logic [31:0] mix;
    logic [31:0] new_word;
    logic        valid_reg;
    logic        op_reg;
    logic [31:0] left_reg;
    logic [31:0] right_reg;

    always_comb
    begin
        upd_left = (odd_stage == stage_in.op);
        sum      = stage_in.op ? dec_sum : enc_sum;
        src      = upd_left ? stage_in.right : stage_in.left;
        dst      = upd_left ? stage_in.left : stage_in.right;
        kidx     = upd_left ? sum[1:0] : sum[12:11];
        mix      = (((src << 4) ^ (src >> 5)) + src) ^ (sum + keys[kidx]);
        new_word = stage_in.op ? (dst - mix) : (dst + mix);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= stage_in.op;
        left_reg  <= upd_left ? new_word : stage_in.left;
        right_reg <= upd_left ? stage_in.right : new_word;
    end

    assign stage_out.valid = valid_reg;
    assign stage_out.op    = op_reg;
    assign stage_out.left  = left_reg;
    assign stage_out.right = right_reg;

endmodule

// ===== tb/sv/xtea_result_checker.sv =====
// Result checker for the XTEA block cipher: watches the key, item and result channels.
// Predicts each result block from its own key copy and compares field by field.
// Depends on xtea_pkg for the item structs, the key type and the round constants.
module xtea_result_checker
    import xtea_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  in_item_t               block,
    input  logic                   result_valid,
    input  out_item_t              result,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data,
    output int                     fail_count,
    output int                     pending_count,
    output int                     checked_count
);

    key_t      key_copy;
    out_item_t expected_blocks[$];
    out_item_t want;

    function automatic logic [31:0] feistel_mix(input logic [31:0] x, input logic [31:0] s,
                                                 input logic [31:0] kw);
        return (((x << 4) ^ (x >> 5)) + x) ^ (s + kw);
    endfunction

    function automatic out_item_t xtea_cipher_block(input in_item_t blk, input key_t k);
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] sum;
        out_item_t   res;
        y = blk.left_word;
        z = blk.right_word;
        if (blk.op == OP_DECRYPT)
        begin
            sum = 32'(ROUNDS) * DELTA;
            for (int r = 0; r < ROUNDS; r++)
            begin
                z = z - feistel_mix(y, sum, k[sum[12:11]]);
                sum = sum - DELTA;
                y = y - feistel_mix(z, sum, k[sum[1:0]]);
            end
        end
        else
        begin
            sum = '0;
            for (int r = 0; r < ROUNDS; r++)
            begin
                y = y + feistel_mix(z, sum, k[sum[1:0]]);
                sum = sum + DELTA;
                z = z + feistel_mix(y, sum, k[sum[12:11]]);
            end
        end
        res.out_left  = y;
        res.out_right = z;
        return res;
    endfunction

    task automatic report_error(input string line);
        $display("ERROR: %s", line);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_copy = '0;
            expected_blocks.delete();
            fail_count = 0;
            pending_count = 0;
            checked_count = 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (expected_blocks.size() == 0)
                begin
                    report_error($sformatf("result %h_%h with no item outstanding",
                                           result.out_left, result.out_right));
                end
                else
                begin
                    want = expected_blocks.pop_front();
                    if (result.out_left !== want.out_left)
                    begin
                        report_error($sformatf("result %0d out_left %h, expected %h",
                                               checked_count, result.out_left, want.out_left));
                    end
                    if (result.out_right !== want.out_right)
                    begin
                        report_error($sformatf("result %0d out_right %h, expected %h",
                                               checked_count, result.out_right,
                                               want.out_right));
                    end
                    checked_count++;
                end
            end
            if (start && !busy)
            begin
                expected_blocks.push_back(xtea_cipher_block(block, key_copy));
            end
            if (cfg_valid && cfg_ready && cfg_index < KEY_WORDS)
            begin
                key_copy[cfg_index[1:0]] = cfg_data;
            end
            pending_count = expected_blocks.size();
        end
    end

endmodule

// ===== tb/sv/tb_xtea_block_cipher.sv =====
// Testbench top for the XTEA block cipher: clock, reset, key writes and item stimulus.
// Instantiates xtea_block_cipher and xtea_result_checker; depends on xtea_pkg.
// Runs directed corner blocks, then random phases under changing keys, and gives the verdict.
module tb_xtea_block_cipher;
    import xtea_pkg::*;

    localparam int   WATCHDOG_LIMIT = 4000;
    localparam int   RANDOM_PHASES  = 10;
    localparam int   PHASE_ITEMS    = 150;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    in_item_t               block = '0;
    logic                   result_valid;
    out_item_t              result;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0]            cfg_data = '0;

    int fail_count;
    int pending_count;
    int checked_count;
    int idle_cycles = 0;
    int encrypt_count = 0;
    int decrypt_count = 0;
    int key_settings = 1;
    bit burst = 1'b0;

    xtea_block_cipher DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .block        (block),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    xtea_result_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .block         (block),
        .result_valid  (result_valid),
        .result        (result),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: nothing accepted for %0d cycles.", WATCHDOG_LIMIT);
                $display("** xtea_block_cipher: FAILED **");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (burst || roll < 50)
        begin
            return 0;
        end
        else if (roll < 88)
        begin
            return $urandom_range(1, 3);
        end
        else if (roll < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h1 << $urandom_range(0, 31);
            3: return ~(32'h1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_block(input logic op, input logic [31:0] lw, input logic [31:0] rw);
        int gap;
        block <= '{op: op, left_word: lw, right_word: rw};
        start <= 1'b1;
        do @(posedge clk); while (busy);
        if (op == OP_DECRYPT)
        begin
            decrypt_count++;
        end
        else
        begin
            encrypt_count++;
        end
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        int gap;
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        gap = pick_gap();
        if (gap > 0)
        begin
            cfg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Writes the selected key words and, optionally, junk to the unused indexes.
    task automatic load_key(input key_t k, input logic [KEY_WORDS-1:0] sel, input bit junk);
        for (int i = 0; i < KEY_WORDS; i++)
        begin
            if (sel[i])
            begin
                write_cfg(CFG_INDEX_W'(i), k[i]);
            end
        end
        if (junk)
        begin
            for (int i = KEY_WORDS; i < (1 << CFG_INDEX_W); i++)
            begin
                write_cfg(CFG_INDEX_W'(i), pick_word());
            end
        end
        cfg_valid <= 1'b0;
        key_settings++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(negedge clk); while (pending_count != 0);
        @(posedge clk);
    endtask

    initial
    begin
        key_t k;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corner blocks under the all-zero reset key.
        send_block(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
        send_block(OP_DECRYPT, 32'h0000_0000, 32'h0000_0000);
        send_block(OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(OP_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_block(OP_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_block(OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
        send_block(OP_DECRYPT, 32'h0000_0001, 32'h8000_0000);
        wait_drained();

        // All-ones key; writes to the unused indexes must leave it alone.
        k = {KEY_WORDS{32'hFFFF_FFFF}};
        load_key(k, '1, 1'b1);
        send_block(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
        send_block(OP_DECRYPT, 32'h0000_0000, 32'h0000_0000);
        send_block(OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(OP_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF);
        send_block(OP_DECRYPT, 32'h89AB_CDEF, 32'h0123_4567);
        wait_drained();

        // Alternating key words show a wrong word selection.
        k = {32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000};
        load_key(k, 4'b0101, 1'b0);
        for (int i = 0; i < 4; i++)
        begin
            send_block(logic'(i[0]), $urandom, $urandom);
        end
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            for (int i = 0; i < KEY_WORDS; i++)
            begin
                k[i] = pick_word();
            end
            load_key(k, (p == 0) ? '1 : KEY_WORDS'($urandom), ($urandom_range(0, 2) == 0));
            burst = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                send_block(logic'($urandom_range(0, 1)), pick_word(), pick_word());
            end
            burst = 1'b0;
            wait_drained();
        end

        repeat (NSTAGE + 16) @(posedge clk);
        $display("Checked %0d result blocks: %0d encryptions and %0d decryptions.",
                 checked_count, encrypt_count, decrypt_count);
        $display("Key settings used: %0d, including the all-zero and all-ones keys.",
                 key_settings);
        if (fail_count == 0 && pending_count == 0)
        begin
            $display("** xtea_block_cipher: PASSED **");
        end
        else
        begin
            $display("** xtea_block_cipher: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/xtea_pkg.sv
src/xtea_key_regs.sv
src/xtea_half_round.sv
src/xtea_block_cipher.sv
tb/sv/xtea_result_checker.sv
tb/sv/tb_xtea_block_cipher.sv
